>>> rtl/bda_pkg.sv
// shared types and constants for the button debouncer with auto-repeat
package bda_pkg;

  localparam int CNT_W = 16;
  localparam int REG_W = 16;
  localparam int DEB_W = 8;
  localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;
  localparam int IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic             RST_ACTIVE_LOW = 1'b1;
  localparam logic [DEB_W-1:0] RST_DEBOUNCE   = DEB_W'(20);
  localparam logic [REG_W-1:0] RST_DELAY      = REG_W'(500);
  localparam logic [REG_W-1:0] RST_RATE       = REG_W'(200);

  typedef logic [IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ACTIVE_LOW = 2'd0;
  localparam cfg_idx_t REG_DEBOUNCE   = 2'd1;
  localparam cfg_idx_t REG_DELAY      = 2'd2;
  localparam cfg_idx_t REG_RATE       = 2'd3;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_REPEAT  = 2'd3
  } event_t;

  typedef struct packed {
    logic             active_low;
    logic [DEB_W-1:0] debounce_ticks;
    logic [REG_W-1:0] repeat_delay;
    logic [REG_W-1:0] repeat_rate;
  } cfg_t;

endpackage

>>> rtl/bda_if.sv
// stream interfaces for sample, result and register write channels
interface bda_in_if;
  logic valid;
  logic ready;
  logic raw_level;
  modport source (output valid, output raw_level, input ready);
  modport sink (input valid, input raw_level, output ready);
endinterface

interface bda_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       pressed;
  modport source (output valid, output event_res, output pressed, input ready);
  modport sink (input valid, input event_res, input pressed, output ready);
endinterface

interface bda_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/bda_core.sv
// debounce and auto-repeat state, one update per step
module bda_core
  import bda_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step,
  input  logic   raw_level,
  input  cfg_t   cfg,
  output event_t ev,
  output logic   pressed
);

  logic             last_r, last_nxt;
  logic             stable_r, stable_nxt;
  logic [CNT_W-1:0] since_change_r, since_change_nxt;
  logic [CNT_W-1:0] since_fire_r, since_fire_nxt;
  logic             pending_r, pending_nxt;

  logic             sample;
  logic [CNT_W-1:0] fire_inc;
  logic [REG_W-1:0] interval;
  logic             deb_ok;

  always_comb begin
    sample   = raw_level ^ cfg.active_low;
    fire_inc = (since_fire_r == CNT_MAX) ? CNT_MAX : since_fire_r + 1'b1;
    interval = pending_r ? cfg.repeat_delay : cfg.repeat_rate;

    last_nxt         = sample;
    stable_nxt       = stable_r;
    pending_nxt      = pending_r;
    since_fire_nxt   = fire_inc;
    ev               = EV_NONE;

    if (sample != last_r) begin
      since_change_nxt = '0;
    end else begin
      since_change_nxt = (since_change_r == CNT_MAX) ? CNT_MAX : since_change_r + 1'b1;
    end

    deb_ok = CMP_W'(since_change_nxt) >= CMP_W'(cfg.debounce_ticks);

    if (deb_ok) begin
      if (sample != stable_r) begin
        stable_nxt = sample;
        if (sample) begin
          since_fire_nxt = '0;
          pending_nxt    = 1'b1;
          ev             = EV_PRESS;
        end else begin
          ev = EV_RELEASE;
        end
      end else if (stable_r && (CMP_W'(fire_inc) >= CMP_W'(interval))) begin
        since_fire_nxt = '0;
        pending_nxt    = 1'b0;
        ev             = EV_REPEAT;
      end
    end

    pressed = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r         <= 1'b0;
      stable_r       <= 1'b0;
      since_change_r <= '0;
      since_fire_r   <= '0;
      pending_r      <= 1'b0;
    end else if (step) begin
      last_r         <= last_nxt;
      stable_r       <= stable_nxt;
      since_change_r <= since_change_nxt;
      since_fire_r   <= since_fire_nxt;
      pending_r      <= pending_nxt;
    end
  end

endmodule

>>> rtl/button_debounce_autorepeat.sv
// top level: debounced push button with press, release and auto-repeat events
//
// in_bus carries one raw pin sample per tick; every accepted beat gives exactly
// one beat on out_bus with the event code (none, press, release, repeat) and the
// debounced pressed state after that sample.
// cfg_bus writes the polarity, debounce time, first repeat delay and repeat
// rate; it is always ready and should only be used while no sample is in flight.
// a sample is captured in an input register, the state update runs in one pass
// of compares and counter increments, and the result lands in the output
// register, whose valid flag stays high on out_bus until the result beat is taken.
// throughput is one sample per cycle while out_bus is ready; the output and
// input registers together let a new sample enter while a finished result
// waits to be taken. when out_bus stalls, the input register holds one more
// sample and in_bus ready drops until the output register is emptied.
// reset restores the register defaults (active low, 20, 500, 200 ticks), clears
// the debounced state, counters and the valid flags of both pipeline registers.
module button_debounce_autorepeat
  import bda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bda_in_if.sink    in_bus,
  bda_out_if.source out_bus,
  bda_cfg_if.sink   cfg_bus
);

  cfg_t   cfg_r;
  logic   in_v_r;
  logic   raw_r;
  logic   out_v_r;
  event_t ev_r;
  logic   pressed_r;

  logic   adv;
  event_t core_ev;
  logic   core_pressed;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low     <= RST_ACTIVE_LOW;
      cfg_r.debounce_ticks <= RST_DEBOUNCE;
      cfg_r.repeat_delay   <= RST_DELAY;
      cfg_r.repeat_rate    <= RST_RATE;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_ACTIVE_LOW: cfg_r.active_low     <= cfg_bus.data[0];
        REG_DEBOUNCE:   cfg_r.debounce_ticks <= cfg_bus.data[DEB_W-1:0];
        REG_DELAY:      cfg_r.repeat_delay   <= cfg_bus.data[REG_W-1:0];
        REG_RATE:       cfg_r.repeat_rate    <= cfg_bus.data[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage moves when the input register holds a sample and the output register is empty or being drained
  assign adv          = in_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      raw_r <= in_bus.raw_level;
    end
  end

  bda_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .raw_level (raw_r),
    .cfg       (cfg_r),
    .ev        (core_ev),
    .pressed   (core_pressed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ev_r      <= core_ev;
      pressed_r <= core_pressed;
    end
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.event_res = ev_r;
  assign out_bus.pressed   = pressed_r;

endmodule

>>> dv/tb_button_debounce_autorepeat.sv
// testbench for the debounced button with auto-repeat: predictor, driver and monitor
`timescale 1ns / 1ps

module tb_button_debounce_autorepeat;
  import bda_pkg::*;

  typedef struct packed {
    event_t ev;
    logic   pressed;
  } tick_result_t;

  typedef enum logic [1:0] {
    ACT_SAMPLE,
    ACT_WRITE,
    ACT_DRAIN,
    ACT_HOLD
  } plan_kind_t;

  typedef struct {
    plan_kind_t  kind;
    logic        raw;
    cfg_idx_t    idx;
    logic [15:0] data;
  } plan_entry_t;

  logic clk = 1'b0;
  logic rst_n;

  bda_in_if  in_if();
  bda_out_if out_if();
  bda_cfg_if cfg_if();

  button_debounce_autorepeat dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_if),
    .out_bus(out_if),
    .cfg_bus(cfg_if)
  );

  always #2 clk = ~clk;

  // predictor state, starts at its reset values
  cfg_t model_cfg = '{active_low: RST_ACTIVE_LOW, debounce_ticks: RST_DEBOUNCE,
                      repeat_delay: RST_DELAY, repeat_rate: RST_RATE};
  logic             last_held     = 1'b0;
  logic             stable_held   = 1'b0;
  logic             first_pending = 1'b0;
  logic [CNT_W-1:0] since_change  = '0;
  logic [CNT_W-1:0] since_fire    = '0;

  tick_result_t expected_events[$];
  plan_entry_t  sample_plan[$];

  int   mismatch_count = 0;
  int   result_beats   = 0;
  int   sample_count   = 0;
  logic plan_low       = RST_ACTIVE_LOW;
  logic plan_level     = 1'b0;

  logic in_fired  = 1'b0;
  logic cfg_fired = 1'b0;
  int   gap_left   = 0;
  int   burst_left = 0;
  int   hold_requests = 0;
  int   holds_served  = 0;
  int   hold_left     = 0;
  int   recv_cycle    = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) $display("mismatch: %s", what);
  endtask

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic tick_result_t debounce_tick(input logic raw);
    tick_result_t     res;
    logic             held;
    logic [CMP_W-1:0] interval;
    held = raw ^ model_cfg.active_low;
    res.ev = EV_NONE;
    since_fire = bump(since_fire);
    if (held != last_held) begin
      last_held = held;
      since_change = '0;
    end else begin
      since_change = bump(since_change);
    end
    if (CMP_W'(since_change) >= CMP_W'(model_cfg.debounce_ticks)) begin
      if (held != stable_held) begin
        stable_held = held;
        if (held) begin
          since_fire = '0;
          first_pending = 1'b1;
          res.ev = EV_PRESS;
        end else begin
          res.ev = EV_RELEASE;
        end
      end else if (stable_held) begin
        interval = first_pending ? CMP_W'(model_cfg.repeat_delay) :
                                   CMP_W'(model_cfg.repeat_rate);
        if (CMP_W'(since_fire) >= interval) begin
          since_fire = '0;
          first_pending = 1'b0;
          res.ev = EV_REPEAT;
        end
      end
    end
    res.pressed = stable_held;
    return res;
  endfunction

  function automatic void apply_write(input cfg_idx_t idx, input logic [15:0] data);
    case (idx)
      REG_ACTIVE_LOW: model_cfg.active_low     = data[0];
      REG_DEBOUNCE:   model_cfg.debounce_ticks = data[DEB_W-1:0];
      REG_DELAY:      model_cfg.repeat_delay   = data[REG_W-1:0];
      REG_RATE:       model_cfg.repeat_rate    = data[REG_W-1:0];
      default: ;
    endcase
  endfunction

  // monitor: handshakes are sampled at the rising edge
  always @(posedge clk) begin
    tick_result_t want;
    in_fired  <= rst_n && in_if.valid && in_if.ready;
    cfg_fired <= rst_n && cfg_if.valid && cfg_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        result_beats++;
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing expected", result_beats));
        end else begin
          want = expected_events.pop_front();
          if (out_if.event_res !== want.ev)
            report_mismatch($sformatf("beat %0d event_res %0d, expected %0d",
                                      result_beats, out_if.event_res, want.ev));
          if (out_if.pressed !== want.pressed)
            report_mismatch($sformatf("beat %0d pressed %0b, expected %0b",
                                      result_beats, out_if.pressed, want.pressed));
        end
      end
      if (cfg_if.valid && cfg_if.ready) apply_write(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) expected_events.push_back(debounce_tick(in_if.raw_level));
    end
  end

  // driver: sender works in bursts, register writes only once all results are back
  always @(negedge clk) begin
    logic        in_v;
    logic        cfg_v;
    logic        raw_nxt;
    cfg_idx_t    idx_nxt;
    logic [15:0] data_nxt;
    in_v     = in_if.valid;
    cfg_v    = cfg_if.valid;
    raw_nxt  = in_if.raw_level;
    idx_nxt  = cfg_if.index;
    data_nxt = cfg_if.data;
    if (in_fired) in_v = 1'b0;
    if (cfg_fired) cfg_v = 1'b0;
    if (rst_n && !in_v && !cfg_v) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_plan.size() > 0) begin
        case (sample_plan[0].kind)
          ACT_SAMPLE: begin
            in_v = 1'b1;
            raw_nxt = sample_plan[0].raw;
            void'(sample_plan.pop_front());
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left = (hold_left > 0 || $urandom_range(0, 2) == 0) ? 0 :
                         $urandom_range(1, 4);
            end
          end
          ACT_WRITE: begin
            if (expected_events.size() == 0) begin
              cfg_v = 1'b1;
              idx_nxt = sample_plan[0].idx;
              data_nxt = sample_plan[0].data;
              void'(sample_plan.pop_front());
            end
          end
          ACT_DRAIN: begin
            if (expected_events.size() == 0) void'(sample_plan.pop_front());
          end
          default: begin
            hold_requests++;
            void'(sample_plan.pop_front());
          end
        endcase
      end
    end
    in_if.valid      <= in_v;
    in_if.raw_level  <= raw_nxt;
    cfg_if.valid     <= cfg_v;
    cfg_if.index     <= idx_nxt;
    cfg_if.data      <= data_nxt;
  end

  // receiver: rotating stall pattern, plus long hold-offs on request
  always @(negedge clk) begin
    logic rdy;
    recv_cycle++;
    if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      case ((recv_cycle / 128) % 4)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = (recv_cycle % 4 == 0);
        default: rdy = ($urandom_range(0, 3) != 0);
      endcase
    end
    out_if.ready <= rdy;
  end

  task automatic add_raw(input logic raw, input int n);
    plan_entry_t e;
    e = '{kind: ACT_SAMPLE, raw: raw, idx: REG_ACTIVE_LOW, data: '0};
    repeat (n) sample_plan.push_back(e);
    sample_count += n;
  endtask

  // level given in pressed sense, turned into a raw level by the planned polarity
  task automatic add_level(input logic held, input int n);
    plan_level = held;
    add_raw(held ^ plan_low, n);
  endtask

  task automatic add_write(input cfg_idx_t idx, input logic [15:0] data);
    sample_plan.push_back('{kind: ACT_DRAIN, raw: 1'b0, idx: idx, data: '0});
    sample_plan.push_back('{kind: ACT_WRITE, raw: 1'b0, idx: idx, data: data});
    if (idx == REG_ACTIVE_LOW) plan_low = data[0];
  endtask

  task automatic add_hold();
    sample_plan.push_back('{kind: ACT_HOLD, raw: 1'b0, idx: REG_ACTIVE_LOW, data: '0});
  endtask

  task automatic random_phase(input int budget);
    int deb;
    int start;
    int k;
    deb = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
    add_write(REG_ACTIVE_LOW, 16'($urandom));
    add_write(REG_DEBOUNCE, {8'($urandom), 8'(deb)});
    add_write(REG_DELAY, ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 30)));
    add_write(REG_RATE, ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 12)));
    start = sample_count;
    while (sample_count - start < budget) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        // clean level run, mostly a toggle so presses and releases follow
        add_level(($urandom_range(0, 3) == 0) ? plan_level : !plan_level,
                  deb + $urandom_range(1, 40));
      end else if (k < 9) begin
        repeat ($urandom_range(2, 5)) add_level(!plan_level, $urandom_range(1, deb + 1));
      end else begin
        repeat ($urandom_range(1, 8)) add_raw(1'($urandom_range(0, 1)), 1);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.raw_level = 1'b1;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_ACTIVE_LOW;
    cfg_if.data = '0;

    // reset defaults: bounce, press, release
    add_level(1'b0, 22);
    add_level(1'b1, 3);
    add_level(1'b0, 2);
    add_level(1'b1, 5);
    add_level(1'b0, 4);
    add_level(1'b1, 30);
    add_hold();
    add_level(1'b1, 20);
    add_level(1'b0, 24);

    // zero debounce and zero intervals, upper data bits set
    add_write(REG_DEBOUNCE, 16'hAB00);
    add_write(REG_DELAY, 16'h0000);
    add_write(REG_RATE, 16'h0000);
    add_level(1'b1, 4);
    add_level(1'b0, 2);
    add_level(1'b1, 1);
    add_level(1'b0, 1);

    // polarity flip with the raw level held
    add_raw(1'b1, 2);
    add_write(REG_ACTIVE_LOW, 16'hFFFE);
    add_raw(1'b1, 3);
    add_write(REG_ACTIVE_LOW, 16'hFFFF);
    add_raw(1'b1, 3);

    add_write(REG_DEBOUNCE, 16'h0001);
    add_write(REG_DELAY, 16'h0001);
    add_write(REG_RATE, 16'h0002);
    add_level(1'b1, 8);
    add_level(1'b0, 3);

    // longer debounce, slow first repeat, then a faster rate
    add_write(REG_DEBOUNCE, 16'h0010);
    add_write(REG_DELAY, 16'h0020);
    add_write(REG_RATE, 16'h0008);
    add_level(1'b1, 70);
    add_level(1'b0, 20);

    for (int p = 0; p < 4; p++) begin
      if (p == 2) add_hold();
      random_phase(40);
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (sample_plan.size() > 0 || in_if.valid || cfg_if.valid ||
           expected_events.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_events.size()));

    if (mismatch_count == 0) begin
      $display("tb_button_debounce_autorepeat passed");
    end else begin
      $display("tb_button_debounce_autorepeat failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_button_debounce_autorepeat failed");
    $finish;
  end

endmodule
